// ===== sv/hpa_pkg.sv =====
// shared types, constants and helper functions for the history peak autorange block
// no dependencies
package hpa_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 180;
  localparam int unsigned VAL_W = 11;

  // peak thresholds in tenths of an ampere
  localparam logic [VAL_W-1:0] LIM_5A  = 11'd50;
  localparam logic [VAL_W-1:0] LIM_10A = 11'd100;
  localparam logic [VAL_W-1:0] LIM_20A = 11'd200;
  localparam logic [VAL_W-1:0] LIM_30A = 11'd300;
  localparam logic [VAL_W-1:0] LIM_50A = 11'd500;
  localparam logic [VAL_W-1:0] LIM_80A = 11'd800;

  // sample count thresholds for the time window
  localparam int unsigned WIN_LIM_5  = 15;
  localparam int unsigned WIN_LIM_15 = 45;
  localparam int unsigned WIN_LIM_30 = 90;

  localparam logic [3:0] COLS_SHORT = 4'd11;
  localparam logic [3:0] COLS_LONG  = 4'd7;

  typedef struct packed {
    logic [VAL_W-1:0] phase1_tenths;
    logic [VAL_W-1:0] phase2_tenths;
    logic [VAL_W-1:0] phase3_tenths;
    logic [VAL_W-1:0] sum_tenths;
    logic             sample_ok;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] phase_peak;
    logic [6:0]       phase_full_scale;
    logic [2:0]       phase_row_lines;
    logic [VAL_W-1:0] sum_peak;
    logic [6:0]       sum_full_scale;
    logic [2:0]       sum_row_lines;
    logic [5:0]       window_minutes;
    logic [7:0]       shown_points;
    logic [3:0]       column_lines;
    logic [7:0]       stored_count;
  } out_item_t;

  // one stored value: gap flag plus current
  typedef struct packed {
    logic             gap;
    logic [VAL_W-1:0] val;
  } series_t;

  // one history row holds all four series
  typedef struct packed {
    series_t ph1;
    series_t ph2;
    series_t ph3;
    series_t sum;
  } hist_entry_t;

  localparam int unsigned ENTRY_W = $bits(hist_entry_t);

  typedef struct packed {
    logic [6:0] full_scale;
    logic [2:0] rows;
  } scale_t;

  function automatic logic [VAL_W-1:0] series_max(input logic [VAL_W-1:0] cur,
                                                  input series_t e);
    logic [VAL_W-1:0] res;
    res = cur;
    if (!e.gap && (e.val > cur)) begin
      res = e.val;
    end
    return res;
  endfunction

  function automatic scale_t pick_scale(input logic [VAL_W-1:0] peak);
    scale_t s;
    if (peak <= LIM_5A) begin
      s = '{full_scale: 7'd5, rows: 3'd6};
    end else if (peak <= LIM_10A) begin
      s = '{full_scale: 7'd10, rows: 3'd5};
    end else if (peak <= LIM_20A) begin
      s = '{full_scale: 7'd20, rows: 3'd5};
    end else if (peak <= LIM_30A) begin
      s = '{full_scale: 7'd30, rows: 3'd4};
    end else if (peak <= LIM_50A) begin
      s = '{full_scale: 7'd50, rows: 3'd6};
    end else if (peak <= LIM_80A) begin
      s = '{full_scale: 7'd80, rows: 3'd5};
    end else begin
      s = '{full_scale: 7'd100, rows: 3'd6};
    end
    return s;
  endfunction

endpackage

// ===== sv/hpa_hist_mem.sv =====
// history store: one row per sample, one write and one registered read port
// depends on hpa_pkg for the row width
module hpa_hist_mem #(
  parameter int unsigned DEPTH = hpa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [hpa_pkg::ENTRY_W-1:0]  wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [hpa_pkg::ENTRY_W-1:0]  rdata
);

  logic [hpa_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [hpa_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/hpa_peak_scan.sv =====
// write sequencer and peak scanner: stores each item in the ring, then reads back
// every filled row and keeps the running peaks; depends on hpa_pkg, hpa_hist_mem
module hpa_peak_scan #(
  parameter int unsigned DEPTH = hpa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hpa_pkg::in_item_t         in_data,
  output logic                      done,
  input  logic                      take,
  output logic [hpa_pkg::VAL_W-1:0] phase_peak,
  output logic [hpa_pkg::VAL_W-1:0] sum_peak,
  output logic [CW-1:0]             fill
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t                    state_r;
  logic [CW-1:0]             fill_r;
  logic [AW-1:0]             ptr_r;
  logic [AW-1:0]             rd_addr_r;
  logic                      rd_pend_r;
  logic [hpa_pkg::VAL_W-1:0] phase_peak_r;
  logic [hpa_pkg::VAL_W-1:0] sum_peak_r;

  logic                      accept;
  logic                      full;
  logic [AW-1:0]             slot;
  hpa_pkg::hist_entry_t      wr_entry;
  logic [hpa_pkg::ENTRY_W-1:0] rd_raw;
  hpa_pkg::hist_entry_t      rd_entry;
  logic                      last_addr;
  logic [hpa_pkg::VAL_W-1:0] phase_acc;
  logic [hpa_pkg::VAL_W-1:0] sum_acc;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == CW'(DEPTH));
  assign slot     = full ? ptr_r : fill_r[AW-1:0];

  always_comb begin
    if (in_data.sample_ok) begin
      wr_entry.ph1 = '{gap: 1'b0, val: in_data.phase1_tenths};
      wr_entry.ph2 = '{gap: 1'b0, val: in_data.phase2_tenths};
      wr_entry.ph3 = '{gap: 1'b0, val: in_data.phase3_tenths};
      wr_entry.sum = '{gap: 1'b0, val: in_data.sum_tenths};
    end else begin
      wr_entry.ph1 = '{gap: 1'b1, val: '0};
      wr_entry.ph2 = '{gap: 1'b1, val: '0};
      wr_entry.ph3 = '{gap: 1'b1, val: '0};
      wr_entry.sum = '{gap: 1'b1, val: '0};
    end
  end

  hpa_hist_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (wr_entry),
    .re    (state_r == S_SCAN),
    .raddr (rd_addr_r),
    .rdata (rd_raw)
  );

  assign rd_entry  = rd_raw;
  // only rows below the fill count are read, so unwritten rows never count
  assign last_addr = (CW'(rd_addr_r) == (fill_r - CW'(1)));

  always_comb begin
    phase_acc = hpa_pkg::series_max(phase_peak_r, rd_entry.ph1);
    phase_acc = hpa_pkg::series_max(phase_acc, rd_entry.ph2);
    phase_acc = hpa_pkg::series_max(phase_acc, rd_entry.ph3);
    sum_acc   = hpa_pkg::series_max(sum_peak_r, rd_entry.sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      ptr_r        <= '0;
      rd_addr_r    <= '0;
      rd_pend_r    <= 1'b0;
      phase_peak_r <= '0;
      sum_peak_r   <= '0;
    end else begin
      rd_pend_r <= (state_r == S_SCAN);
      if (rd_pend_r) begin
        phase_peak_r <= phase_acc;
        sum_peak_r   <= sum_acc;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (full) begin
              ptr_r <= (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);
            end else begin
              fill_r <= fill_r + CW'(1);
            end
            rd_addr_r    <= '0;
            phase_peak_r <= '0;
            sum_peak_r   <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_addr_r <= rd_addr_r + AW'(1);
          if (last_addr) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last row's data is folded in on this edge
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done       = (state_r == S_DONE);
  assign phase_peak = phase_peak_r;
  assign sum_peak   = sum_peak_r;
  assign fill       = fill_r;

endmodule

// ===== sv/history_peak_autorange_core.sv =====
// top level: history peak autorange with range mapping and result register
// depends on hpa_pkg, hpa_peak_scan (which holds hpa_hist_mem)
//
// Usage:
//   in_valid/in_ready/in_data carry one 20-second sample (three phase currents,
//   a total and a valid flag). A sample with sample_ok low stores a gap.
//   out_valid/out_ready/out_data carry one result per sample: the peak phase
//   and total current over the whole history, their chart ranges and grid
//   lines, and the time window picked from the number of stored samples.
//   Scan: an item is written into the history ring on its accept edge, then
//   every filled row (N = samples held, up to HISTORY_DEPTH) is read back one
//   row a cycle from the single read port of the history memory. The peaks
//   are registered once the last row is folded in, and a new item is taken
//   only after that result has moved on to the output register.
//   Reset empties the history at once: the fill count goes to zero and only
//   rows below it are ever read, so no clearing pass is needed.
//   If the receiver stalls, the result waits in the output register while the
//   next item is taken and scanned; that item's result then waits until the
//   output register is free.
module history_peak_autorange_core #(
  parameter int unsigned HISTORY_DEPTH = hpa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hpa_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  logic                      done;
  logic                      take;
  logic [hpa_pkg::VAL_W-1:0] phase_peak;
  logic [hpa_pkg::VAL_W-1:0] sum_peak;
  logic [CW-1:0]             fill;
  logic [31:0]               fill_ext;
  hpa_pkg::scale_t           phase_sc;
  hpa_pkg::scale_t           sum_sc;
  logic [5:0]                window;
  hpa_pkg::out_item_t        res;

  logic                      out_valid_r;
  hpa_pkg::out_item_t        out_data_r;

  hpa_peak_scan #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .done       (done),
    .take       (take),
    .phase_peak (phase_peak),
    .sum_peak   (sum_peak),
    .fill       (fill)
  );

  assign take     = done && (!out_valid_r || out_ready);
  assign fill_ext = 32'(fill);
  assign phase_sc = hpa_pkg::pick_scale(phase_peak);
  assign sum_sc   = hpa_pkg::pick_scale(sum_peak);

  always_comb begin
    if (fill_ext <= hpa_pkg::WIN_LIM_5) begin
      window = 6'd5;
    end else if (fill_ext <= hpa_pkg::WIN_LIM_15) begin
      window = 6'd15;
    end else if (fill_ext <= hpa_pkg::WIN_LIM_30) begin
      window = 6'd30;
    end else begin
      window = 6'd60;
    end
  end

  always_comb begin
    res.phase_peak       = phase_peak;
    res.phase_full_scale = phase_sc.full_scale;
    res.phase_row_lines  = phase_sc.rows;
    res.sum_peak         = sum_peak;
    res.sum_full_scale   = sum_sc.full_scale;
    res.sum_row_lines    = sum_sc.rows;
    res.window_minutes   = window;
    // three points per minute
    res.shown_points     = {1'b0, window, 1'b0} + {2'b00, window};
    res.column_lines     = (window == 6'd5) ? hpa_pkg::COLS_SHORT : hpa_pkg::COLS_LONG;
    res.stored_count     = fill_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/history_peak_autorange_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for history_peak_autorange_core: a local model of the
// sample history predicts every result, which is checked field by field
// depends on hpa_pkg and history_peak_autorange_core
module history_peak_autorange_core_tb;

  localparam int unsigned DEPTH = hpa_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hpa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hpa_pkg::out_item_t out_data;

  history_peak_autorange_core #(
    .HISTORY_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // local copy of the history
  hpa_pkg::series_t hist_ph1 [DEPTH];
  hpa_pkg::series_t hist_ph2 [DEPTH];
  hpa_pkg::series_t hist_ph3 [DEPTH];
  hpa_pkg::series_t hist_sum [DEPTH];
  int unsigned held = 0;
  int unsigned ring_oldest = 0;

  // chart range table, indexed by the first limit the peak does not exceed
  logic [hpa_pkg::VAL_W-1:0] range_lim [6];
  int unsigned range_amps [7] = '{5, 10, 20, 30, 50, 80, 100};
  int unsigned range_rows [7] = '{6, 5, 5, 4, 6, 5, 6};

  hpa_pkg::out_item_t expected_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int gap_samples = 0;
  int results_checked = 0;
  int overwrites = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hpa_pkg::scale_t chart_range(input logic [hpa_pkg::VAL_W-1:0] pk);
    hpa_pkg::scale_t r;
    int k;
    k = 0;
    while (k < 6 && pk > range_lim[k]) k++;
    r.full_scale = 7'(range_amps[k]);
    r.rows = 3'(range_rows[k]);
    return r;
  endfunction

  function automatic hpa_pkg::series_t stored_value(input logic ok,
                                                    input logic [hpa_pkg::VAL_W-1:0] v);
    hpa_pkg::series_t e;
    e.gap = !ok;
    e.val = ok ? v : '0;
    return e;
  endfunction

  // writes one sample into the history and works out the result it causes
  function automatic hpa_pkg::out_item_t predict_sample(input hpa_pkg::in_item_t s);
    int unsigned slot;
    int unsigned win;
    logic [hpa_pkg::VAL_W-1:0] ph_pk;
    logic [hpa_pkg::VAL_W-1:0] sm_pk;
    hpa_pkg::scale_t ph_rng;
    hpa_pkg::scale_t sm_rng;
    hpa_pkg::out_item_t r;
    if (held < DEPTH) begin
      slot = held;
      held++;
    end else begin
      slot = ring_oldest;
      ring_oldest = (ring_oldest + 1) % DEPTH;
      overwrites++;
    end
    hist_ph1[slot] = stored_value(s.sample_ok, s.phase1_tenths);
    hist_ph2[slot] = stored_value(s.sample_ok, s.phase2_tenths);
    hist_ph3[slot] = stored_value(s.sample_ok, s.phase3_tenths);
    hist_sum[slot] = stored_value(s.sample_ok, s.sum_tenths);
    ph_pk = '0;
    sm_pk = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!hist_ph1[i].gap && hist_ph1[i].val > ph_pk) ph_pk = hist_ph1[i].val;
      if (!hist_ph2[i].gap && hist_ph2[i].val > ph_pk) ph_pk = hist_ph2[i].val;
      if (!hist_ph3[i].gap && hist_ph3[i].val > ph_pk) ph_pk = hist_ph3[i].val;
      if (!hist_sum[i].gap && hist_sum[i].val > sm_pk) sm_pk = hist_sum[i].val;
    end
    ph_rng = chart_range(ph_pk);
    sm_rng = chart_range(sm_pk);
    if (held <= hpa_pkg::WIN_LIM_5) win = 5;
    else if (held <= hpa_pkg::WIN_LIM_15) win = 15;
    else if (held <= hpa_pkg::WIN_LIM_30) win = 30;
    else win = 60;
    r.phase_peak = ph_pk;
    r.phase_full_scale = ph_rng.full_scale;
    r.phase_row_lines = ph_rng.rows;
    r.sum_peak = sm_pk;
    r.sum_full_scale = sm_rng.full_scale;
    r.sum_row_lines = sm_rng.rows;
    r.window_minutes = 6'(win);
    r.shown_points = 8'(3 * win);
    r.column_lines = (win == 5) ? hpa_pkg::COLS_SHORT : hpa_pkg::COLS_LONG;
    r.stored_count = held[7:0];
    return r;
  endfunction

  function automatic hpa_pkg::in_item_t make_sample(input logic ok, input int unsigned p1,
                                                    input int unsigned p2,
                                                    input int unsigned p3,
                                                    input int unsigned sm);
    hpa_pkg::in_item_t s;
    s.sample_ok = ok;
    s.phase1_tenths = hpa_pkg::VAL_W'(p1);
    s.phase2_tenths = hpa_pkg::VAL_W'(p2);
    s.phase3_tenths = hpa_pkg::VAL_W'(p3);
    s.sum_tenths = hpa_pkg::VAL_W'(sm);
    return s;
  endfunction

  // leaves in_valid high on return; drain_results lowers it, the next call only for an idle gap
  task automatic send_sample(input hpa_pkg::in_item_t s);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) gap++;
      // now and then a longer pause so gaps land at any point of the scan
      if ($urandom_range(19) == 0) gap += $urandom_range(DEPTH + 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_sample(s));
    samples_sent++;
    if (!s.sample_ok) gap_samples++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // empty history, all-gap history, every range boundary on phases and total
  task automatic test_directed_ranges();
    int unsigned bnd [12] = '{50, 51, 100, 101, 200, 201, 300, 301, 500, 501, 800, 801};
    idle_pct = 0;
    stall_pct = 0;
    send_sample(make_sample(1'b0, 2047, 2047, 2047, 2047));
    send_sample(make_sample(1'b1, 0, 0, 0, 0));
    for (int i = 0; i < 12; i++) begin
      send_sample(make_sample(1'b1, (i % 3 == 0) ? bnd[i] : 0, (i % 3 == 1) ? bnd[i] : 0,
                              (i % 3 == 2) ? bnd[i] : 0, bnd[i]));
    end
    send_sample(make_sample(1'b1, 2047, 2047, 2047, 0));
    send_sample(make_sample(1'b0, 0, 0, 0, 0));
    send_sample(make_sample(1'b1, 0, 0, 0, 2047));
    drain_results();
  endtask

  // random samples; the value ceiling moves between ranges so the peaks fall
  // again once large values leave the history
  task automatic test_random_traffic(input int n, input int idle, input int stall);
    int unsigned caps [7] = '{50, 100, 200, 300, 500, 800, 2047};
    int cap_idx;
    hpa_pkg::in_item_t s;
    idle_pct = idle;
    stall_pct = stall;
    cap_idx = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) cap_idx = $urandom_range(6);
      s = make_sample($urandom_range(9) != 0, $urandom_range(caps[cap_idx]),
                      $urandom_range(caps[cap_idx]), $urandom_range(caps[cap_idx]),
                      $urandom_range(caps[cap_idx]));
      if ($urandom_range(99) == 0) s.sum_tenths = 11'd2047;
      send_sample(s);
    end
    drain_results();
  endtask

  // a full history's worth of gaps: peaks must return to zero
  task automatic test_gap_flush(input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < DEPTH + 5; i++) begin
      send_sample(make_sample(1'b0, $urandom_range(2047), $urandom_range(2047),
                              $urandom_range(2047), $urandom_range(2047)));
    end
    drain_results();
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    hpa_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no sample outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("phase_peak", 32'(want.phase_peak), 32'(out_data.phase_peak));
        check_field("phase_full_scale", 32'(want.phase_full_scale),
                    32'(out_data.phase_full_scale));
        check_field("phase_row_lines", 32'(want.phase_row_lines),
                    32'(out_data.phase_row_lines));
        check_field("sum_peak", 32'(want.sum_peak), 32'(out_data.sum_peak));
        check_field("sum_full_scale", 32'(want.sum_full_scale),
                    32'(out_data.sum_full_scale));
        check_field("sum_row_lines", 32'(want.sum_row_lines), 32'(out_data.sum_row_lines));
        check_field("window_minutes", 32'(want.window_minutes),
                    32'(out_data.window_minutes));
        check_field("shown_points", 32'(want.shown_points), 32'(out_data.shown_points));
        check_field("column_lines", 32'(want.column_lines), 32'(out_data.column_lines));
        check_field("stored_count", 32'(want.stored_count), 32'(out_data.stored_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("history_peak_autorange_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    range_lim[0] = hpa_pkg::LIM_5A;
    range_lim[1] = hpa_pkg::LIM_10A;
    range_lim[2] = hpa_pkg::LIM_20A;
    range_lim[3] = hpa_pkg::LIM_30A;
    range_lim[4] = hpa_pkg::LIM_50A;
    range_lim[5] = hpa_pkg::LIM_80A;
    for (int i = 0; i < DEPTH; i++) begin
      hist_ph1[i] = stored_value(1'b0, '0);
      hist_ph2[i] = stored_value(1'b0, '0);
      hist_ph3[i] = stored_value(1'b0, '0);
      hist_sum[i] = stored_value(1'b0, '0);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ranges();
    test_random_traffic(190, 0, 0);
    test_random_traffic(150, 50, 0);
    test_gap_flush(0, 50);
    test_random_traffic(155, 0, 50);
    test_random_traffic(150, 18, 18);

    stall_pct = 0;
    repeat (DEPTH + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("sent %0d samples (%0d gaps), checked %0d results", samples_sent, gap_samples,
             results_checked);
    $display("history ring overwrote %0d entries; idle and stall mixes all exercised",
             overwrites);
    if (mismatches == 0) begin
      $display("history_peak_autorange_core verification clean");
    end else begin
      $display("history_peak_autorange_core verification failed");
    end
    $finish;
  end

endmodule
